/* rtl/hfd_pkg.sv */
// Package for the HTTP/2 frame deframer: beat and frame types, header
// constants and the client connection preface table.
// No dependencies; used by every module of the block.
`default_nettype none

package hfd_pkg;

  // Stream widths: tdata is padded up to whole bytes.
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 184;

  localparam logic [4:0] PREFACE_LEN   = 5'd24;
  localparam logic [3:0] HDR_LEN       = 4'd9;
  localparam logic [24:0] PRIORITY_LEN = 25'd5;
  localparam logic [7:0] FLAG_PADDED   = 8'h08;
  localparam logic [7:0] FLAG_PRIORITY = 8'h20;
  localparam logic [7:0] TYPE_HEADERS  = 8'h01;
  localparam logic [7:0] SID_TOP_MASK  = 8'h7f;

  // Byte position inside the 9-byte frame header.
  typedef enum logic [3:0] {
    HDR_LEN_HI  = 4'd0,
    HDR_LEN_MID = 4'd1,
    HDR_LEN_LO  = 4'd2,
    HDR_TYPE    = 4'd3,
    HDR_FLAGS   = 4'd4,
    HDR_SID_3   = 4'd5,
    HDR_SID_2   = 4'd6,
    HDR_SID_1   = 4'd7,
    HDR_SID_0   = 4'd8
  } hdr_pos_e;

  // One captured byte with its tags.
  typedef struct packed {
    logic        dir;
    logic [7:0]  data;
    logic [62:0] ts;
  } hfd_beat_t;

  // Snapshot of a completed frame header.
  typedef struct packed {
    logic        dir;
    logic [30:0] sid;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [23:0] len;
    logic [7:0]  pad;
    logic [62:0] ts;
  } hfd_frame_t;

  // One frame event as it leaves the block.
  typedef struct packed {
    logic        frame_direction;
    logic [30:0] stream_num;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_flags;
    logic [23:0] payload_length;
    logic [62:0] frame_timestamp;
    logic        block_present;
    logic [23:0] block_offset;
    logic [23:0] block_length;
  } hfd_event_t;

  // Client connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n".
  function automatic logic [7:0] preface_byte(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:    val = 8'h50;
      5'd1:    val = 8'h52;
      5'd2:    val = 8'h49;
      5'd3:    val = 8'h20;
      5'd4:    val = 8'h2a;
      5'd5:    val = 8'h20;
      5'd6:    val = 8'h48;
      5'd7:    val = 8'h54;
      5'd8:    val = 8'h54;
      5'd9:    val = 8'h50;
      5'd10:   val = 8'h2f;
      5'd11:   val = 8'h32;
      5'd12:   val = 8'h2e;
      5'd13:   val = 8'h30;
      5'd14:   val = 8'h0d;
      5'd15:   val = 8'h0a;
      5'd16:   val = 8'h0d;
      5'd17:   val = 8'h0a;
      5'd18:   val = 8'h53;
      5'd19:   val = 8'h4d;
      5'd20:   val = 8'h0d;
      5'd21:   val = 8'h0a;
      5'd22:   val = 8'h0d;
      5'd23:   val = 8'h0a;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/hfd_parser.sv */
// Per-direction frame parser: preface matcher, header capture and payload
// skip, with a register that holds the header of each completed frame.
// Depends on hfd_pkg.
`default_nettype none

module hfd_parser
  import hfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire hfd_beat_t  beat_i,
  input  wire logic       adv_i,
  output logic            frame_valid_o,
  output hfd_frame_t      frame_o
);

  logic             preface_done_q, preface_done_d;
  logic [4:0]       pre_pos_q, pre_pos_d;
  logic [1:0][3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [1:0]       in_pay_q, in_pay_d;
  logic [1:0][23:0] len_q, len_d;
  logic [1:0][7:0]  type_q, type_d;
  logic [1:0][7:0]  flags_q, flags_d;
  logic [1:0][30:0] sid_q, sid_d;
  logic [1:0][23:0] rem_q, rem_d;
  logic [1:0][7:0]  pad_q, pad_d;

  logic             emit;
  logic [4:0]       pos;
  logic [3:0]       hpos;
  logic             d;
  logic [7:0]       b;
  hfd_frame_t       frame_d;
  logic             frame_valid_q;
  hfd_frame_t       frame_q;

  // Next state for the direction of the current beat.
  always_comb begin
    d               = beat_i.dir;
    b               = beat_i.data;
    preface_done_d  = preface_done_q;
    pre_pos_d       = pre_pos_q;
    hdr_cnt_d       = hdr_cnt_q;
    in_pay_d        = in_pay_q;
    len_d           = len_q;
    type_d          = type_q;
    flags_d         = flags_q;
    sid_d           = sid_q;
    rem_d           = rem_q;
    pad_d           = pad_q;
    emit            = 1'b0;
    pos             = (pre_pos_q >= PREFACE_LEN) ? 5'd0 : pre_pos_q;
    hpos            = (hdr_cnt_q[d] >= HDR_LEN) ? 4'd0 : hdr_cnt_q[d];
    if (fire_i) begin
      if (!d && !preface_done_q) begin
        // Client preface; a mismatching byte is dropped and matching restarts.
        if (b == preface_byte(pos)) begin
          if (pos == PREFACE_LEN - 5'd1) begin
            preface_done_d = 1'b1;
            pre_pos_d      = 5'd0;
          end else begin
            pre_pos_d = pos + 5'd1;
          end
        end else begin
          pre_pos_d = 5'd0;
        end
      end else if (!in_pay_q[d]) begin
        // Frame header capture.
        case (hdr_pos_e'(hpos))
          HDR_LEN_HI:  len_d[d]         = {b, 16'h0000};
          HDR_LEN_MID: len_d[d][15:8]   = b;
          HDR_LEN_LO:  len_d[d][7:0]    = b;
          HDR_TYPE:    type_d[d]        = b;
          HDR_FLAGS:   flags_d[d]       = b;
          HDR_SID_3:   sid_d[d]         = {b[6:0] & SID_TOP_MASK[6:0], 24'h000000};
          HDR_SID_2:   sid_d[d][23:16]  = b;
          HDR_SID_1:   sid_d[d][15:8]   = b;
          HDR_SID_0:   sid_d[d][7:0]    = b;
          default:     sid_d[d][7:0]    = b;
        endcase
        if (hpos == HDR_LEN - 4'd1) begin
          hdr_cnt_d[d] = 4'd0;
          if (len_q[d] == 24'd0) begin
            emit = 1'b1;
          end else begin
            in_pay_d[d] = 1'b1;
            rem_d[d]    = len_q[d];
          end
        end else begin
          hdr_cnt_d[d] = hpos + 4'd1;
        end
      end else begin
        // Payload skip; the first payload byte is kept as the pad length.
        if (rem_q[d] == len_q[d]) begin
          pad_d[d] = b;
        end
        rem_d[d] = rem_q[d] - 24'd1;
        if (rem_d[d] == 24'd0) begin
          in_pay_d[d] = 1'b0;
          emit        = 1'b1;
        end
      end
    end
  end

  // Header snapshot taken from the updated state of this direction.
  always_comb begin
    frame_d.dir   = d;
    frame_d.sid   = sid_d[d];
    frame_d.ftype = type_d[d];
    frame_d.flags = flags_d[d];
    frame_d.len   = len_d[d];
    frame_d.pad   = pad_d[d];
    frame_d.ts    = beat_i.ts;
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preface_done_q <= 1'b0;
      pre_pos_q      <= 5'd0;
      hdr_cnt_q      <= '0;
      in_pay_q       <= '0;
      len_q          <= '0;
      type_q         <= '0;
      flags_q        <= '0;
      sid_q          <= '0;
      rem_q          <= '0;
      pad_q          <= '0;
    end else begin
      preface_done_q <= preface_done_d;
      pre_pos_q      <= pre_pos_d;
      hdr_cnt_q      <= hdr_cnt_d;
      in_pay_q       <= in_pay_d;
      len_q          <= len_d;
      type_q         <= type_d;
      flags_q        <= flags_d;
      sid_q          <= sid_d;
      rem_q          <= rem_d;
      pad_q          <= pad_d;
    end
  end

  // Completed-frame register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
    end else if (adv_i) begin
      frame_valid_q <= fire_i && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && fire_i && emit) begin
      frame_q <= frame_d;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  // Once the preface is seen it is never matched again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    preface_done_q |=> preface_done_q)
    else $error("preface_done cleared after it was set");

  // Header counters stay within the nine header bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q[0] < HDR_LEN) && (hdr_cnt_q[1] < HDR_LEN))
    else $error("header counter out of range");

  // A direction in its payload always has bytes left to skip.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_pay_q[0] || (rem_q[0] != 24'd0)) && (!in_pay_q[1] || (rem_q[1] != 24'd0)))
    else $error("payload state with nothing remaining");

endmodule

`default_nettype wire

/* rtl/hfd_block_calc.sv */
// Header-block locator: strips pad length, padding and priority fields from
// a completed HEADERS frame and holds the event in the output register.
// Depends on hfd_pkg.
`default_nettype none

module hfd_block_calc
  import hfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       frame_valid_i,
  input  wire hfd_frame_t frame_i,
  input  wire logic       out_ready_i,
  output logic            ready_o,
  output logic            out_valid_o,
  output hfd_event_t      event_o
);

  logic        present;
  logic [23:0] off;
  logic [23:0] fin;
  logic [24:0] off_pri;
  hfd_event_t  ev_d;
  hfd_event_t  ev_q;
  logic        out_valid_q;

  // Block start and end inside the payload.
  always_comb begin
    present = (frame_i.ftype == TYPE_HEADERS) && (frame_i.sid != 31'd0);
    off     = 24'd0;
    fin     = frame_i.len;
    if (((frame_i.flags & FLAG_PADDED) != 8'h00) && (frame_i.len != 24'd0)) begin
      if ({16'h0000, frame_i.pad} > (frame_i.len - 24'd1)) begin
        off = frame_i.len;
      end else begin
        off = 24'd1;
        fin = frame_i.len - {16'h0000, frame_i.pad};
      end
    end
    off_pri = {1'b0, off} + PRIORITY_LEN;
    if ((frame_i.flags & FLAG_PRIORITY) != 8'h00) begin
      off = (off_pri > {1'b0, fin}) ? fin : off_pri[23:0];
    end
  end

  // Event fields.
  always_comb begin
    ev_d.frame_direction = frame_i.dir;
    ev_d.stream_num      = frame_i.sid;
    ev_d.frame_kind      = frame_i.ftype;
    ev_d.frame_flags     = frame_i.flags;
    ev_d.payload_length  = frame_i.len;
    ev_d.frame_timestamp = frame_i.ts;
    ev_d.block_present   = present;
    ev_d.block_offset    = present ? off : 24'd0;
    ev_d.block_length    = present ? (fin - off) : 24'd0;
  end

  assign ready_o = !out_valid_q || out_ready_i;

  // Output register; it refills in the cycle the waiting beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && frame_valid_i) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_o     = ev_q;

  // A header block never reaches past the payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q.block_present) |->
      (({1'b0, ev_q.block_offset} + {1'b0, ev_q.block_length}) <=
       {1'b0, ev_q.payload_length}))
    else $error("header block beyond payload end");

  // Frames without a header block report an empty block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ev_q.block_present) |->
      ((ev_q.block_offset == 24'd0) && (ev_q.block_length == 24'd0)))
    else $error("block fields set without a header block");

  // A stalled output beat stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(ev_q)))
    else $error("output beat changed while stalled");

endmodule

`default_nettype wire

/* rtl/http2_frame_deframer_core.sv */
// HTTP/2 frame deframer top level: input register, parser and block locator.
// Depends on hfd_pkg, hfd_parser and hfd_block_calc.
//
// Usage:
//   The slave stream carries one captured byte per beat: tuser is the
//   direction (0 client to server, 1 server to client), tdata holds the byte
//   and its 63-bit timestamp. The client direction must first carry the
//   24-byte connection preface; bytes that break the match are dropped.
//   The master stream carries one beat per completed frame, issued on the
//   frame's last byte, with the header fields and, for HEADERS on a nonzero
//   stream, the header-block offset and length inside the payload.
//   Throughput is one byte per cycle while the master side takes beats: the
//   per-direction counters update when the parser accepts the registered byte.
//   A byte passes the input register, the parser's frame register and the
//   output register before its event shows on the master side.
//   Reset clears all frame state and the preface match, and drops any beats
//   in flight. When the receiver stalls, up to three beats are held in the
//   input, frame and output registers before tready falls.
`default_nettype none

module http2_frame_deframer_core
  import hfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // data_byte, timestamp
  input  wire logic                 s_axis_tuser,   // direction
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,   // stream_num, frame_kind, frame_flags,
                                                    // payload_length, frame_timestamp,
                                                    // block_present, block_offset,
                                                    // block_length
  output logic                      m_axis_tuser    // frame_direction
);

  hfd_beat_t  beat_q;
  logic       beat_valid_q;
  logic       frame_valid;
  hfd_frame_t frame;
  logic       calc_ready;
  logic       frame_ready;
  logic       fire;
  hfd_event_t ev;

  assign frame_ready   = !frame_valid || calc_ready;
  assign fire          = beat_valid_q && frame_ready;
  assign s_axis_tready = !beat_valid_q || frame_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      beat_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      beat_q.dir  <= s_axis_tuser;
      beat_q.data <= s_axis_tdata[7:0];
      beat_q.ts   <= s_axis_tdata[70:8];
    end
  end

  hfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .beat_i        (beat_q),
    .adv_i         (frame_ready),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  hfd_block_calc u_block_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .out_ready_i   (m_axis_tready),
    .ready_o       (calc_ready),
    .out_valid_o   (m_axis_tvalid),
    .event_o       (ev)
  );

  // Output packing, first field in the lowest bits.
  assign m_axis_tuser = ev.frame_direction;
  assign m_axis_tdata = {1'b0, ev.block_length, ev.block_offset, ev.block_present,
                         ev.frame_timestamp, ev.payload_length, ev.frame_flags,
                         ev.frame_kind, ev.stream_num};

endmodule

`default_nettype wire
